// ===== hdl/mks_pkg.sv =====
// Package for the Mahalanobis k-nearest-neighbour selector.
// Holds the shared constants, request codes, register indices, controller states and the command and status structs.
`timescale 1ns / 1ps
package mks_pkg;
   localparam int MAX_K       = 16;
   localparam int LIST_DEPTH  = MAX_K + 1;
   localparam int FRAC_BITS   = 16;
   localparam int IDX_W       = 12;
   localparam int DIST_W      = 64;
   localparam int POS_W       = $clog2(LIST_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_ROW    = 2'd0,
      REQ_CENTER = 2'd1,
      REQ_CAND   = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_K_COUNT  = 3'd0,
      REG_SKIP     = 3'd1,
      REG_MIX      = 3'd2,
      REG_RAD_EN   = 3'd3,
      REG_RAD_LIM  = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_SQ,
      ST_ACC,
      ST_INSERT,
      ST_EMIT,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic load_row;
      logic load_center;
      logic load_cand;
      logic mul_step;
      logic sum_step;
      logic sq_step;
      logic acc_step;
      logic insert_step;
      logic emit_load;
      logic emit_advance;
   } cmd_type;

   typedef struct packed {
      logic axis_done;
      logic sq_done;
      logic emit_more;
      logic emit_last;
   } status_type;
endpackage

// ===== hdl/mks_datapath.sv =====
// Datapath of the selector: matrix, centre, distance arithmetic and sorted list.
// Depends on mks_pkg and is driven by mks_control.
`timescale 1ns / 1ps
module mks_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mks_pkg::cmd_type               cmd,
   output mks_pkg::status_type            status,
   input  logic [1:0]                     row_select,
   input  logic signed [31:0]             value_a,
   input  logic signed [31:0]             value_b,
   input  logic signed [31:0]             value_c,
   input  logic [mks_pkg::IDX_W-1:0]      point_index,
   input  logic [4:0]                     k_count,
   input  logic                           skip_self,
   input  logic                           mix_euclid,
   input  logic                           radius_enable,
   input  logic [63:0]                    radius_limit,
   output logic [mks_pkg::IDX_W-1:0]      out_index,
   output logic [63:0]                    out_distance,
   output logic                           out_found,
   output logic                           out_last
);
   localparam int PW = mks_pkg::POS_W;
   localparam int LD = mks_pkg::LIST_DEPTH;

   logic signed [31:0] mat_ff [9];
   logic signed [31:0] ctr_ff [3];
   logic signed [31:0] d_ff [3];
   logic [mks_pkg::IDX_W-1:0] idx_ff;
   logic [1:0] axis_ff;
   logic signed [63:0] prod_ff [3];
   logic signed [31:0] w_ff;
   logic [63:0] sq_ff;
   logic [63:0] dist_ff;
   logic [2:0] sq_cnt_ff;
   logic [63:0] bd_ff [LD];
   logic [mks_pkg::IDX_W-1:0] bi_ff [LD];
   logic [PW-1:0] cnt_ff;
   logic [PW-1:0] rd_ff;
   logic [PW-1:0] nvalid_ff;

   logic [4:0] k_sat;
   logic [PW-1:0] cap;
   logic [PW-1:0] n_cur;
   logic signed [32:0] diff [3];
   logic signed [31:0] dsat [3];
   logic signed [49:0] hi_sum;
   logic [17:0] lo_sum;
   logic signed [49:0] wfull;
   logic signed [31:0] wsat;
   logic signed [31:0] sq_src;
   logic [64:0] acc_sum;
   logic [LD-1:0] le_vec;
   logic [PW-1:0] pos;
   logic [PW-1:0] start;
   logic rd_ok;

   always_comb begin
      k_sat = (k_count == 5'd0) ? 5'd1 : ((k_count > 5'(mks_pkg::MAX_K)) ?
              5'(mks_pkg::MAX_K) : k_count);
      cap = PW'(k_sat) + PW'(skip_self);
      n_cur = (cnt_ff < cap) ? cnt_ff : cap;
      for (int i = 0; i < 3; i++) begin
         diff[i] = 33'(d_ff[i]) - 33'(ctr_ff[i]);
         if (diff[i] > 33'sd2147483647) dsat[i] = 32'sh7fffffff;
         else if (diff[i] < -33'sd2147483648) dsat[i] = 32'sh80000000;
         else dsat[i] = diff[i][31:0];
      end
      hi_sum = '0;
      lo_sum = '0;
      for (int c = 0; c < 3; c++) begin
         hi_sum = hi_sum + 50'(prod_ff[c] >>> mks_pkg::FRAC_BITS);
         lo_sum = lo_sum + 18'(prod_ff[c][mks_pkg::FRAC_BITS-1:0]);
      end
      wfull = hi_sum + 50'(lo_sum >> mks_pkg::FRAC_BITS);
      if (wfull > 50'sd2147483647) wsat = 32'sh7fffffff;
      else if (wfull < -50'sd2147483648) wsat = 32'sh80000000;
      else wsat = wfull[31:0];
      sq_src = w_ff;
      acc_sum = 65'(dist_ff) + 65'(sq_ff);
      for (int i = 0; i < LD; i++)
         le_vec[i] = (PW'(i) < n_cur) && (bd_ff[i] <= dist_ff);
      pos = '0;
      for (int i = 0; i < LD; i++)
         if (le_vec[i]) pos = PW'(i + 1);
      start = (skip_self && n_cur != '0) ? PW'(1) : '0;
      rd_ok = (rd_ff < nvalid_ff) &&
              !(radius_enable && bd_ff[rd_ff[PW-1:0] < PW'(LD) ? rd_ff : '0] >= radius_limit);
   end

   assign status.axis_done = (axis_ff == 2'd2);
   assign status.sq_done   = (sq_cnt_ff == (mix_euclid ? 3'd5 : 3'd2));
   assign status.emit_more = rd_ok;
   assign status.emit_last = out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) mat_ff[i] <= '0;
         for (int i = 0; i < 3; i++) ctr_ff[i] <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.load_row && row_select != 2'd3) begin
            mat_ff[4'(row_select) * 4'd3]        <= value_a;
            mat_ff[4'(row_select) * 4'd3 + 4'd1] <= value_b;
            mat_ff[4'(row_select) * 4'd3 + 4'd2] <= value_c;
         end
         if (cmd.load_center) begin
            ctr_ff[0] <= value_a; ctr_ff[1] <= value_b; ctr_ff[2] <= value_c;
            cnt_ff <= '0;
         end
         if (cmd.insert_step) begin
            if (pos < cap) begin
               for (int i = 1; i < LD; i++)
                  if (PW'(i) > pos && PW'(i) <= n_cur && PW'(i) < cap) begin
                     bd_ff[i] <= bd_ff[i-1];
                     bi_ff[i] <= bi_ff[i-1];
                  end
               bd_ff[pos[PW-1:0] < PW'(LD) ? pos : '0] <= dist_ff;
               bi_ff[pos[PW-1:0] < PW'(LD) ? pos : '0] <= idx_ff;
               cnt_ff <= (n_cur < cap) ? n_cur + PW'(1) : cap;
            end else begin
               cnt_ff <= n_cur;
            end
         end
         if (cmd.emit_load) cnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cand) begin
         d_ff[0] <= value_a; d_ff[1] <= value_b; d_ff[2] <= value_c;
         idx_ff <= point_index;
         axis_ff <= 2'd0;
         dist_ff <= '0;
         sq_cnt_ff <= '0;
      end
      if (cmd.mul_step) begin
         if (axis_ff == 2'd0 && sq_cnt_ff == 3'd0)
            for (int i = 0; i < 3; i++) d_ff[i] <= dsat[i];
         for (int c = 0; c < 3; c++)
            prod_ff[c] <= mat_ff[4'(axis_ff) * 4'd3 + 4'(c)] *
                          ((axis_ff == 2'd0) ? dsat[c] : d_ff[c]);
      end
      if (cmd.sum_step) w_ff <= wsat;
      if (cmd.sq_step) begin
         if (sq_cnt_ff < 3'd3) sq_ff <= 64'(sq_src * sq_src);
         else sq_ff <= 64'(d_ff[2'(sq_cnt_ff - 3'd3)] * d_ff[2'(sq_cnt_ff - 3'd3)]);
      end
      if (cmd.acc_step) begin
         dist_ff <= acc_sum[64] ? '1 : acc_sum[63:0];
         sq_cnt_ff <= sq_cnt_ff + 3'd1;
         if (axis_ff != 2'd2) axis_ff <= axis_ff + 2'd1;
      end
      if (cmd.emit_load) begin
         rd_ff <= start;
         nvalid_ff <= n_cur;
      end
      if (cmd.emit_advance) rd_ff <= rd_ff + PW'(1);
   end

   always_comb begin
      out_found = rd_ok;
      out_index = rd_ok ? bi_ff[rd_ff < PW'(LD) ? rd_ff : '0] : '0;
      out_distance = rd_ok ? bd_ff[rd_ff < PW'(LD) ? rd_ff : '0] : '0;
      out_last = !rd_ok || !((rd_ff + PW'(1) < nvalid_ff) && !(radius_enable &&
                 bd_ff[(rd_ff + PW'(1) < PW'(LD)) ? rd_ff + PW'(1) : '0] >= radius_limit));
   end
endmodule

// ===== hdl/mks_control.sv =====
// Controller of the selector: sequences the distance steps, insertion and emission.
// Depends on mks_pkg and drives mks_datapath.
`timescale 1ns / 1ps
module mks_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  logic [1:0]                req_kind,
   input  logic                      req_last,
   input  mks_pkg::status_type       status,
   input  logic                      rsp_free,
   output logic                      req_ready,
   output logic                      rsp_load,
   output mks_pkg::cmd_type          cmd
);
   mks_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mks_pkg::ST_IDLE;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         mks_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               unique case (req_kind)
                  mks_pkg::REQ_ROW:    cmd.load_row = 1'b1;
                  mks_pkg::REQ_CENTER: cmd.load_center = 1'b1;
                  mks_pkg::REQ_CAND: begin
                     cmd.load_cand = 1'b1;
                     last_in = req_last;
                     state_in = mks_pkg::ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         mks_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in = mks_pkg::ST_SUM;
         end
         mks_pkg::ST_SUM: begin
            cmd.sum_step = 1'b1;
            state_in = mks_pkg::ST_SQ;
         end
         mks_pkg::ST_SQ: begin
            cmd.sq_step = 1'b1;
            state_in = mks_pkg::ST_ACC;
         end
         mks_pkg::ST_ACC: begin
            cmd.acc_step = 1'b1;
            if (status.sq_done) state_in = mks_pkg::ST_INSERT;
            else if (status.axis_done) state_in = mks_pkg::ST_SQ;
            else state_in = mks_pkg::ST_MUL;
         end
         mks_pkg::ST_INSERT: begin
            cmd.insert_step = 1'b1;
            state_in = last_ff ? mks_pkg::ST_WAIT : mks_pkg::ST_IDLE;
         end
         mks_pkg::ST_WAIT: begin
            cmd.emit_load = 1'b1;
            state_in = mks_pkg::ST_EMIT;
         end
         mks_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (status.emit_more) cmd.emit_advance = 1'b1;
               if (status.emit_last) state_in = mks_pkg::ST_IDLE;
            end
         end
         default: state_in = mks_pkg::ST_IDLE;
      endcase
   end
endmodule

// ===== hdl/mahalanobis_knn_select.sv =====
// Top level of the Mahalanobis k-nearest-neighbour selector.
// Depends on mks_pkg, mks_control and mks_datapath.
//
// Requests arrive on req_ (tdata: req_type, row_select, value_a, value_b, value_c,
// point_index; tlast: last_candidate). Matrix rows and centres are written as they are accepted.
// A candidate goes through acceptance, three passes of multiply, sum, square and
// accumulate through the row multipliers and the single shared squaring multiplier,
// three further square and accumulate passes for the Euclidean term, and the
// parallel insertion. After the last candidate the list bounds are latched in a wait state,
// and the results leave on rsp_ nearest first, one per cycle while the receiver
// takes them; rsp_tlast marks the final one. An empty answer is one item with
// found clear. The result register holds its item while rsp_tready is low, and
// the block waits until it can load the next one.
// Configuration is written through csr_; the user must write it only while the
// block is idle, which the block itself does not enforce.
// Reset clears the matrix, the centre, the list and the registers to defaults.
`timescale 1ns / 1ps
module mahalanobis_knn_select (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_type[1:0], row_select[3:2], value_a[35:4], value_b[67:36],
   // value_c[99:68], point_index[111:100]
   input  logic [111:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // neighbor_index[11:0], neighbor_distance[75:12], zero fill above
   output logic [79:0]  rsp_tdata,
   // found[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);
   logic [4:0]  k_count_ff;
   logic        skip_self_ff, mix_euclid_ff, radius_enable_ff;
   logic [63:0] radius_limit_ff;
   logic        rsp_valid_ff;
   logic [79:0] rsp_data_ff;
   logic        rsp_user_ff, rsp_last_ff;

   mks_pkg::cmd_type    cmd;
   mks_pkg::status_type status;
   logic rsp_load, rsp_free, req_fire;
   logic [11:0] o_idx;
   logic [63:0] o_dist;
   logic o_found, o_last;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff <= 5'd8;
         skip_self_ff <= 1'b1;
         mix_euclid_ff <= 1'b0;
         radius_enable_ff <= 1'b0;
         radius_limit_ff <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            mks_pkg::REG_K_COUNT: k_count_ff <= csr_data[4:0];
            mks_pkg::REG_SKIP:    skip_self_ff <= csr_data[0];
            mks_pkg::REG_MIX:     mix_euclid_ff <= csr_data[0];
            mks_pkg::REG_RAD_EN:  radius_enable_ff <= csr_data[0];
            mks_pkg::REG_RAD_LIM: radius_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {4'd0, o_dist, o_idx};
         rsp_user_ff <= o_found;
         rsp_last_ff <= o_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   mks_control u_control (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .req_kind(req_tdata[1:0]), .req_last(req_tlast), .status(status),
      .rsp_free(rsp_free), .req_ready(req_tready), .rsp_load(rsp_load), .cmd(cmd)
   );

   mks_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .row_select(req_tdata[3:2]), .value_a(req_tdata[35:4]),
      .value_b(req_tdata[67:36]), .value_c(req_tdata[99:68]),
      .point_index(req_tdata[111:100]), .k_count(k_count_ff),
      .skip_self(skip_self_ff), .mix_euclid(mix_euclid_ff),
      .radius_enable(radius_enable_ff), .radius_limit(radius_limit_ff),
      .out_index(o_idx), .out_distance(o_dist), .out_found(o_found), .out_last(o_last)
   );
endmodule

// ===== hdl/mks_checker.sv =====
// Port checker for the selector, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
module mks_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed while stalled.");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("Empty answer malformed.");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("Request taken during emission.");
endmodule

bind mahalanobis_knn_select mks_checker u_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for mahalanobis_knn_select.
// Predicts each query answer with a behavioural k-nearest-neighbour model and checks every result.
// Depends on mks_pkg and the mahalanobis_knn_select RTL.
`timescale 1ns / 1ps
module testbench;
   typedef struct packed {
      logic [11:0] index;
      logic [63:0] distance;
      logic        found;
      logic        last;
   } neighbour_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [79:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   mahalanobis_knn_select dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Model state
   logic [4:0]          k_reg;
   logic                skip_reg, mix_reg, rad_en_reg;
   logic [63:0]         rad_lim_reg;
   logic signed [31:0]  coeff [9];
   logic signed [31:0]  centre [3];
   logic [63:0]         list_dist [mks_pkg::LIST_DEPTH];
   logic [11:0]         list_idx [mks_pkg::LIST_DEPTH];
   int                  list_count;
   neighbour_type       expected_neighbours [$];

   int send_idle = 0, recv_idle = 0, hold_cycles = 0, errors = 0;
   longint cycles = 0;

   function automatic logic signed [31:0] sat32(logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7fffffff;
      if (x < -66'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] mahalanobis_distance(logic signed [31:0] d [3]);
      logic [63:0]         total;
      logic signed [65:0]  acc;
      logic signed [63:0]  p;
      logic signed [31:0]  w;
      total = 0;
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int c = 0; c < 3; c++) begin
            p = coeff[r*3+c] * d[c];
            acc += p;
         end
         w = sat32(acc >>> mks_pkg::FRAC_BITS);
         total = add_sat(total, 64'(w * w));
      end
      if (mix_reg)
         for (int c = 0; c < 3; c++) total = add_sat(total, 64'(d[c] * d[c]));
      return total;
   endfunction

   function automatic int list_capacity();
      int k;
      k = k_reg < 1 ? 1 : (k_reg > mks_pkg::MAX_K ? mks_pkg::MAX_K : k_reg);
      return k + skip_reg;
   endfunction

   function automatic void insert_candidate(logic [63:0] cand_dist, logic [11:0] idx);
      int cap, n, pos;
      cap = list_capacity();
      n = list_count < cap ? list_count : cap;
      pos = 0;
      while (pos < n && list_dist[pos] <= cand_dist) pos++;
      if (pos >= cap) begin
         list_count = n;
         return;
      end
      for (int i = (n < cap) ? n : cap - 1; i > pos; i--) begin
         list_dist[i] = list_dist[i-1];
         list_idx[i] = list_idx[i-1];
      end
      list_dist[pos] = cand_dist;
      list_idx[pos] = idx;
      list_count = (n < cap) ? n + 1 : cap;
   endfunction

   function automatic void predict_request(logic [111:0] data, logic last);
      mks_pkg::req_kind_type kind;
      logic signed [31:0]  v [3];
      logic signed [31:0]  d [3];
      int                  cap, n, cnt;
      neighbour_type       item;
      kind = mks_pkg::req_kind_type'(data[1:0]);
      v[0] = data[35:4];
      v[1] = data[67:36];
      v[2] = data[99:68];
      case (kind)
         mks_pkg::REQ_ROW: begin
            if (data[3:2] < 3)
               for (int c = 0; c < 3; c++) coeff[data[3:2]*3+c] = v[c];
         end
         mks_pkg::REQ_CENTER: begin
            centre = v;
            list_count = 0;
         end
         mks_pkg::REQ_CAND: begin
            for (int c = 0; c < 3; c++) d[c] = sat32(66'(v[c]) - 66'(centre[c]));
            insert_candidate(mahalanobis_distance(d), data[111:100]);
            if (last) begin
               cap = list_capacity();
               n = list_count < cap ? list_count : cap;
               cnt = 0;
               for (int i = (skip_reg && n > 0) ? 1 : 0; i < n; i++) begin
                  if (rad_en_reg && list_dist[i] >= rad_lim_reg) break;
                  item = '{list_idx[i], list_dist[i], 1'b1, 1'b0};
                  expected_neighbours.insert(expected_neighbours.size(), item);
                  cnt++;
               end
               if (cnt == 0) begin
                  item = '{12'd0, 64'd0, 1'b0, 1'b1};
                  expected_neighbours.insert(expected_neighbours.size(), item);
               end else expected_neighbours[$].last = 1'b1;
               list_count = 0;
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      neighbour_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_neighbours.size() == 0) begin
            $error("unexpected result index=%0d", rsp_tdata[11:0]);
            errors++;
         end else begin
            exp_item = expected_neighbours.pop_front();
            if (rsp_tdata[11:0] !== exp_item.index) begin
               $error("neighbor_index expected %0d actual %0d", exp_item.index, rsp_tdata[11:0]);
               errors++;
            end
            if (rsp_tdata[75:12] !== exp_item.distance) begin
               $error("neighbor_distance expected %h actual %h", exp_item.distance,
                      rsp_tdata[75:12]);
               errors++;
            end
            if (rsp_tuser !== exp_item.found) begin
               $error("found expected %0d actual %0d", exp_item.found, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== exp_item.last) begin
               $error("last_result expected %0d actual %0d", exp_item.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   task automatic send_request(mks_pkg::req_kind_type kind, logic [1:0] row, logic [31:0] a,
                               logic [31:0] b, logic [31:0] c, logic [11:0] idx,
                               logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {idx, c, b, a, row, kind};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request({idx, c, b, a, row, kind}, last);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (expected_neighbours.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(mks_pkg::reg_index_type index, logic [63:0] value);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (index)
         mks_pkg::REG_K_COUNT: k_reg = value[4:0];
         mks_pkg::REG_SKIP:    skip_reg = value[0];
         mks_pkg::REG_MIX:     mix_reg = value[0];
         mks_pkg::REG_RAD_EN:  rad_en_reg = value[0];
         mks_pkg::REG_RAD_LIM: rad_lim_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
         default: return 32'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   task automatic load_matrix(bit identity);
      for (int r = 0; r < 3; r++)
         if (identity)
            send_request(mks_pkg::REQ_ROW, 2'(r), r == 0 ? 32'h10000 : 0,
                         r == 1 ? 32'h10000 : 0, r == 2 ? 32'h10000 : 0, 12'd0, 1'b0);
         else
            send_request(mks_pkg::REQ_ROW, 2'(r),
                         $urandom_range(1) ? $urandom : $urandom_range(131072),
                         $urandom_range(65535), $urandom, 12'($urandom),
                         1'($urandom_range(1)));
   endtask

   task automatic run_query(int n_cand);
      send_request(mks_pkg::REQ_CENTER, 2'($urandom), rand_coord(), rand_coord(),
                   rand_coord(), 12'($urandom), 1'($urandom_range(1)));
      for (int i = 0; i < n_cand; i++) begin
         if ($urandom_range(19) == 0)
            send_request(mks_pkg::REQ_NONE, 2'($urandom), $urandom, $urandom, $urandom,
                         12'($urandom), 1'b0);
         send_request(mks_pkg::REQ_CAND, 2'($urandom), rand_coord(), rand_coord(),
                      rand_coord(), 12'($urandom), i == n_cand - 1);
      end
   endtask

   task automatic test_directed();
      load_matrix(1);
      send_request(mks_pkg::REQ_ROW, 2'd3, '1, '1, '1, 0, 0);
      send_request(mks_pkg::REQ_NONE, 0, '1, '1, '1, '1, 1);
      // The list starts empty after reset: a skip on a single candidate gives an empty answer.
      send_request(mks_pkg::REQ_CAND, 0, 0, 0, 0, 12'd5, 1);
      send_request(mks_pkg::REQ_CENTER, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0);
      send_request(mks_pkg::REQ_CAND, 0, 32'h7fffffff, 32'h80000000, 32'h80000000,
                   12'hfff, 0);
      send_request(mks_pkg::REQ_CAND, 0, 32'h80000000, 32'h7fffffff, 0, 12'd0, 0);
      send_request(mks_pkg::REQ_CAND, 0, 32'h80000000, 32'h7fffffff, 0, 12'd1, 0);
      send_request(mks_pkg::REQ_CAND, 0, 32'h80010000, 32'h7fffffff, 0, 12'd2, 1);
      send_request(mks_pkg::REQ_ROW, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
      send_request(mks_pkg::REQ_ROW, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
      send_request(mks_pkg::REQ_CENTER, 0, 0, 0, 0, 0, 0);
      send_request(mks_pkg::REQ_CAND, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   12'd7, 0);
      send_request(mks_pkg::REQ_CAND, 0, 32'hffffffff, 32'h1, 32'hffff0000, 12'd8, 1);
      drain();
   endtask

   task automatic test_settings();
      write_register(mks_pkg::REG_K_COUNT, 0);
      write_register(mks_pkg::REG_SKIP, 0);
      write_register(mks_pkg::REG_MIX, 1);
      load_matrix(0);
      run_query(5);
      drain();
      write_register(mks_pkg::REG_K_COUNT, 31);
      write_register(mks_pkg::REG_RAD_EN, 1);
      write_register(mks_pkg::REG_RAD_LIM, 64'h0000_4000_0000_0000);
      run_query(20);
      drain();
      write_register(mks_pkg::REG_K_COUNT, 16);
      write_register(mks_pkg::REG_SKIP, 1);
      write_register(mks_pkg::REG_RAD_LIM, 0);
      run_query(3);
      drain();
      write_register(mks_pkg::REG_RAD_LIM, '1);
      write_register(mks_pkg::REG_MIX, 0);
      write_register(mks_pkg::REG_K_COUNT, 3);
      load_matrix(1);
      run_query(6);
      drain();
   endtask

   task automatic test_random(int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         int n;
         n = $urandom_range(1, 12);
         if ($urandom_range(3) == 0) begin
            load_matrix($urandom_range(1));
            sent += 3;
         end
         run_query(n);
         sent += n + 1;
      end
   endtask

   task automatic test_backpressure();
      write_register(mks_pkg::REG_K_COUNT, 16);
      write_register(mks_pkg::REG_RAD_EN, 0);
      hold_cycles = 400;
      run_query(12);
      run_query(6);
      drain();
   endtask

   initial begin
      k_reg = 8;
      skip_reg = 1;
      mix_reg = 0;
      rad_en_reg = 0;
      rad_lim_reg = '1;
      coeff = '{default: 0};
      centre = '{default: 0};
      list_count = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_settings();
      send_idle = 20;
      recv_idle = 65;
      test_random(10);
      drain();
      write_register(mks_pkg::REG_MIX, 64'($urandom_range(1)));
      send_idle = 65;
      recv_idle = 20;
      test_random(10);
      drain();
      send_idle = 0;
      recv_idle = 0;
      test_random(10);
      drain();
      test_backpressure();
      drain();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
